// ----- rtl/pdpp_pkg.sv -----
// Shared constants, types and the pattern table for the 2x2 pattern dither page packer.
// No dependencies; pdpp_front, pdpp_pattern, pdpp_out_buf and the top level import this package.
`timescale 1ns / 1ps

package pdpp_pkg;

    localparam int FRAME_WIDTH    = 128;
    localparam int FRAME_HEIGHT   = 64;

    localparam int COL_W          = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
    localparam int ROW_W          = $clog2(FRAME_HEIGHT);
    localparam int PAIRS          = FRAME_WIDTH / 2;
    localparam int PAIR_AW        = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int LAST_BLOCK_COL = (FRAME_WIDTH / 2) * 2 - 1;
    localparam int LAST_PAGE_ROW  = (FRAME_HEIGHT / 8) * 8 - 1;

    localparam logic [7:0] THRESH_1 = 8'd51;
    localparam logic [7:0] THRESH_2 = 8'd102;
    localparam logic [7:0] THRESH_3 = 8'd153;
    localparam logic [7:0] THRESH_4 = 8'd204;

    // pattern bits: top-left, top-right, bottom-left, bottom-right
    localparam logic [3:0] PAT_NONE  = 4'h0;
    localparam logic [3:0] PAT_ONE   = 4'h2;
    localparam logic [3:0] PAT_TWO   = 4'h6;
    localparam logic [3:0] PAT_THREE = 4'hE;
    localparam logic [3:0] PAT_ALL   = 4'hF;

    // item held between the input register and the result register
    typedef struct packed {
        logic [7:0]         gray;
        logic [7:0]         left;
        logic [2:0]         bbit;
        logic               blk;
        logic               first;
        logic               emit;
        logic               fend;
        logic [2:0]         page;
        logic [6:0]         col;
        logic [PAIR_AW-1:0] addr;
    } pdpp_item_t;

    // two finished page bytes of one block
    typedef struct packed {
        logic [7:0] left_byte;
        logic [7:0] right_byte;
        logic [6:0] right_col;
        logic [2:0] page;
        logic       fend;
    } pdpp_pair_t;

    function automatic logic [3:0] pick_pattern(input logic [7:0] avg);
        logic [3:0] pat;
        if (avg < THRESH_1) begin
            pat = PAT_NONE;
        end else if (avg < THRESH_2) begin
            pat = PAT_ONE;
        end else if (avg < THRESH_3) begin
            pat = PAT_TWO;
        end else if (avg < THRESH_4) begin
            pat = PAT_THREE;
        end else begin
            pat = PAT_ALL;
        end
        return pat;
    endfunction

endpackage

// ----- rtl/pdpp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pdpp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/pdpp_front.sv -----
// Raster counters, left pixel, even-row line store and the input register stage.
// Depends on pdpp_pkg and pdpp_ram.
`timescale 1ns / 1ps

module pdpp_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        s1_adv,
    output logic                        s1_valid,
    output pdpp_pkg::pdpp_item_t        s1_item,
    output logic [15:0]                 top_pair,
    output logic                        acc_rd_en,
    output logic [pdpp_pkg::PAIR_AW-1:0] acc_rd_addr
);

    import pdpp_pkg::*;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [7:0]         left_reg;
    logic               s1_valid_reg;
    pdpp_item_t         item_reg, item_next;
    logic               accept;
    logic               blk;
    logic               st_wr;
    logic [PAIR_AW-1:0] pair_addr;

    assign s_tready  = !s1_valid_reg || s1_adv;
    assign accept    = s_tvalid && s_tready;
    assign blk       = row_reg[0] && col_reg[0];
    assign st_wr     = accept && !row_reg[0] && col_reg[0];
    assign pair_addr = PAIR_AW'(col_reg >> 1);

    assign acc_rd_en   = accept && blk;
    assign acc_rd_addr = pair_addr;

    // even row: keep the pixel pair {right, left} at its block address
    pdpp_ram #(
        .WIDTH(16),
        .DEPTH(PAIRS)
    ) u_line_store (
        .aclk   (aclk),
        .wr_en  (st_wr),
        .wr_addr(pair_addr),
        .wr_data({s_tdata, left_reg}),
        .rd_en  (accept && blk),
        .rd_addr(pair_addr),
        .rd_data(top_pair)
    );

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_reg == COL_W'(FRAME_WIDTH - 1)) begin
                col_next = '0;
                if (row_reg == ROW_W'(FRAME_HEIGHT - 1)) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb begin
        item_next       = item_reg;
        item_next.gray  = s_tdata;
        item_next.left  = left_reg;
        item_next.bbit  = row_reg[2:0];
        item_next.blk   = blk;
        item_next.first = (row_reg[2:0] == 3'd1);
        item_next.emit  = blk && (row_reg[2:0] == 3'd7)
                          && (row_reg <= ROW_W'(LAST_PAGE_ROW));
        item_next.fend  = (row_reg == ROW_W'(LAST_PAGE_ROW))
                          && (col_reg == COL_W'(LAST_BLOCK_COL));
        item_next.page  = 3'(row_reg >> 3);
        item_next.col   = 7'(col_reg);
        item_next.addr  = pair_addr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            left_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept) begin
                left_reg     <= s_tdata;
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = item_reg;

endmodule

// ----- rtl/pdpp_pattern.sv -----
// Block average, pattern pick and page accumulator merge for one 2x2 block.
// Depends on pdpp_pkg.
`timescale 1ns / 1ps

module pdpp_pattern (
    input  pdpp_pkg::pdpp_item_t item,
    input  logic [15:0]          top_pair,
    input  logic [15:0]          acc_pair,
    output logic [15:0]          acc_wr_data,
    output pdpp_pkg::pdpp_pair_t pair
);

    import pdpp_pkg::*;

    logic [9:0] sum;
    logic [7:0] avg;
    logic [3:0] pat;
    logic [2:0] tbit;
    logic [7:0] tmask;
    logic [7:0] bmask;
    logic [7:0] keep;
    logic [7:0] lcol;
    logic [7:0] rcol;
    logic [7:0] new_l;
    logic [7:0] new_r;

    assign sum   = 10'(top_pair[7:0]) + 10'(top_pair[15:8])
                 + 10'(item.left) + 10'(item.gray);
    assign avg   = sum[9:2];
    assign pat   = pick_pattern(avg);
    assign tbit  = item.bbit - 3'd1;
    assign tmask = 8'b1 << tbit;
    assign bmask = 8'b1 << item.bbit;
    assign keep  = ~(tmask | bmask);

    assign lcol = (pat[0] ? tmask : 8'h00) | (pat[2] ? bmask : 8'h00);
    assign rcol = (pat[1] ? tmask : 8'h00) | (pat[3] ? bmask : 8'h00);

    // first row pair of a page overwrites stale bits
    assign new_l = item.first ? lcol : ((acc_pair[7:0] & keep) | lcol);
    assign new_r = item.first ? rcol : ((acc_pair[15:8] & keep) | rcol);

    assign acc_wr_data     = {new_r, new_l};
    assign pair.left_byte  = new_l;
    assign pair.right_byte = new_r;
    assign pair.right_col  = item.col;
    assign pair.page       = item.page;
    assign pair.fend       = item.fend;

endmodule

// ----- rtl/pdpp_out_buf.sv -----
// Result register holding both page bytes of one block, sent left column first.
// Depends on pdpp_pkg.
`timescale 1ns / 1ps

module pdpp_out_buf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  pdpp_pkg::pdpp_pair_t pair,
    output logic                 out_free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);

    import pdpp_pkg::*;

    logic       valid_reg;
    logic       second_reg;
    pdpp_pair_t pair_reg;
    logic       pop;
    logic [7:0] byte_sel;
    logic [6:0] col_sel;

    assign pop      = valid_reg && m_tready;
    assign out_free = !valid_reg || (m_tready && second_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else if (load) begin
            valid_reg  <= 1'b1;
            second_reg <= 1'b0;
        end else if (pop) begin
            // advance to the right byte, drop after it
            if (second_reg) begin
                valid_reg <= 1'b0;
            end else begin
                second_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pair_reg <= pair;
        end
    end

    assign byte_sel = second_reg ? pair_reg.right_byte : pair_reg.left_byte;
    assign col_sel  = second_reg ? pair_reg.right_col
                                 : {pair_reg.right_col[6:1], 1'b0};

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0, pair_reg.page, col_sel, byte_sel};
    assign m_tlast  = second_reg;
    assign m_tuser  = second_reg && pair_reg.fend;

endmodule

// ----- rtl/pattern_dither_page_packer.sv -----
// 2x2 pattern dither with page packing: one gray pixel per transaction in raster order.
// Throughput: one pixel per cycle unless the output stalls; two page bytes leave per odd
// pixel of a page's last row. The left byte passes the input register, then the result register;
// the right byte follows in the cycle after the left one is taken; the two-byte result register
// sets the rate when the output stalls. Reset clears counters, left pixel and valid flags;
// the line store and page accumulator need no clearing and no pass after reset.
`timescale 1ns / 1ps

module pattern_dither_page_packer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] gray
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] page_byte, [14:8] column_index, [17:15] page_index
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // [0] frame_end
);

    import pdpp_pkg::*;

    logic               s1_valid;
    logic               s1_adv;
    pdpp_item_t         s1_item;
    logic [15:0]        top_pair;
    logic [15:0]        acc_pair;
    logic [15:0]        acc_wr_data;
    logic               acc_rd_en;
    logic [PAIR_AW-1:0] acc_rd_addr;
    logic               out_free;
    pdpp_pair_t         pair;

    assign s1_adv = s1_valid && (!s1_item.emit || out_free);

    pdpp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s1_adv     (s1_adv),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item),
        .top_pair   (top_pair),
        .acc_rd_en  (acc_rd_en),
        .acc_rd_addr(acc_rd_addr)
    );

    pdpp_ram #(
        .WIDTH(16),
        .DEPTH(PAIRS)
    ) u_page_acc (
        .aclk   (aclk),
        .wr_en  (s1_adv && s1_item.blk),
        .wr_addr(s1_item.addr),
        .wr_data(acc_wr_data),
        .rd_en  (acc_rd_en),
        .rd_addr(acc_rd_addr),
        .rd_data(acc_pair)
    );

    pdpp_pattern u_pattern (
        .item       (s1_item),
        .top_pair   (top_pair),
        .acc_pair   (acc_pair),
        .acc_wr_data(acc_wr_data),
        .pair       (pair)
    );

    pdpp_out_buf u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (s1_adv && s1_item.emit),
        .pair    (pair),
        .out_free(out_free),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule

// ----- rtl/pdpp_checker.sv -----
// Port-level checks for the pattern dither page packer, bound to the top level.
// Depends on pattern_dither_page_packer.
`timescale 1ns / 1ps

module pdpp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // right byte follows the left one without a gap
    a_pair_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("right byte missing after left byte");

    // left bytes sit on even columns, right bytes on odd ones
    a_col_parity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8] == m_tlast))
        else $error("column parity does not match byte position");

    a_fend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end on a left byte");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind pattern_dither_page_packer pdpp_checker u_pdpp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
);

// ----- test/pattern_dither_page_packer_tb.sv -----
// Self-checking bench for pattern_dither_page_packer: random gray pixels in, page bytes out.
// Predicts the 2x2 dither and page packing in-bench; depends on rtl/pdpp_pkg.sv and the RTL.
`timescale 1ns / 1ps

module pattern_dither_page_packer_tb;

    localparam int W          = pdpp_pkg::FRAME_WIDTH;
    localparam int H          = pdpp_pkg::FRAME_HEIGHT;
    localparam int LAST_ROW   = pdpp_pkg::LAST_PAGE_ROW;
    localparam int LAST_COL   = pdpp_pkg::LAST_BLOCK_COL;
    // a full first page of rows and a little more, so a whole page of bytes comes out
    localparam int PIXEL_CNT  = 1100;
    localparam int CYCLE_CAP  = 1_000_000;
    localparam int TAIL_WAIT  = 16;

    typedef struct {
        logic [7:0] gray;
        bit         drain;
    } pixel_t;

    typedef struct packed {
        logic [7:0] pbyte;
        logic [6:0] col;
        logic [2:0] page;
        logic       fend;
        logic       last;
    } page_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] gray
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [7:0] page_byte, [14:8] column_index, [17:15] page_index
    logic        m_tlast;           // run_last
    logic        m_tuser;           // [0] frame_end

    pixel_t     pixels_pending[$];
    page_byte_t page_bytes_due[$];

    // predictor state
    logic [7:0] line_store [W];
    logic [7:0] page_acc [W];
    int         pred_row  = 0;
    int         pred_col  = 0;
    logic [7:0] pred_left = 8'd0;

    int   errors     = 0;
    int   cycles     = 0;
    bit   in_taken   = 1'b0;
    bit   out_taken  = 1'b0;
    int   tx_gap     = 0;
    int   tx_max     = 0;
    int   rx_stall   = 0;
    int   rx_max     = 0;
    int   sent_cnt   = 0;
    int   recv_cnt   = 0;
    logic v_next;
    logic [7:0] d_next;

    logic [7:0] opening_px [24] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd50, 8'd51, 8'd101, 8'd102,
                                    8'd152, 8'd153, 8'd203, 8'd204, 8'h55, 8'hAA, 8'h01,
                                    8'h80, 8'h7F, 8'hFE, 8'd255, 8'd255, 8'd0, 8'd0, 8'd128,
                                    8'd127};
    logic [7:0] level_marks [10] = '{8'd0, 8'd50, 8'd51, 8'd101, 8'd102, 8'd152, 8'd153,
                                     8'd203, 8'd204, 8'd255};

    pattern_dither_page_packer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic logic [3:0] block_pattern(input int avg);
        if (avg < pdpp_pkg::THRESH_1) return pdpp_pkg::PAT_NONE;
        if (avg < pdpp_pkg::THRESH_2) return pdpp_pkg::PAT_ONE;
        if (avg < pdpp_pkg::THRESH_3) return pdpp_pkg::PAT_TWO;
        if (avg < pdpp_pkg::THRESH_4) return pdpp_pkg::PAT_THREE;
        return pdpp_pkg::PAT_ALL;
    endfunction

    // advance the frame model by one pixel and queue the page bytes it finishes
    task automatic dither_pixel(input logic [7:0] g);
        int         sum;
        logic [3:0] pat;
        int         tbit;
        int         bbit;
        logic [7:0] lbits;
        logic [7:0] rbits;
        logic [7:0] keep;
        page_byte_t pb;
        if (pred_row % 2 == 0) begin
            line_store[pred_col] = g;
        end else if (pred_col % 2 == 1) begin
            sum   = line_store[pred_col-1] + line_store[pred_col] + pred_left + g;
            pat   = block_pattern(sum / 4);
            tbit  = (pred_row - 1) % 8;
            bbit  = pred_row % 8;
            lbits = 8'd0;
            rbits = 8'd0;
            // pattern bits: top-left, top-right, bottom-left, bottom-right
            if (pat[0]) lbits[tbit] = 1'b1;
            if (pat[2]) lbits[bbit] = 1'b1;
            if (pat[1]) rbits[tbit] = 1'b1;
            if (pat[3]) rbits[bbit] = 1'b1;
            if (bbit == 1) begin
                // first row pair of a page: overwrite, drop bits of the previous page
                page_acc[pred_col-1] = lbits;
                page_acc[pred_col]   = rbits;
            end else begin
                keep = 8'hFF;
                keep[tbit] = 1'b0;
                keep[bbit] = 1'b0;
                page_acc[pred_col-1] = (page_acc[pred_col-1] & keep) | lbits;
                page_acc[pred_col]   = (page_acc[pred_col] & keep) | rbits;
            end
            if (bbit == 7 && pred_row <= LAST_ROW) begin
                pb.pbyte = page_acc[pred_col-1];
                pb.col   = 7'(pred_col - 1);
                pb.page  = 3'(pred_row / 8);
                pb.fend  = 1'b0;
                pb.last  = 1'b0;
                page_bytes_due.push_back(pb);
                pb.pbyte = page_acc[pred_col];
                pb.col   = 7'(pred_col);
                pb.fend  = (pred_row == LAST_ROW && pred_col == LAST_COL);
                pb.last  = 1'b1;
                page_bytes_due.push_back(pb);
            end
        end
        pred_left = g;
        pred_col++;
        if (pred_col >= W) begin
            pred_col = 0;
            pred_row = (pred_row + 1 >= H) ? 0 : pred_row + 1;
        end
    endtask

    task automatic compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic check_page_byte();
        page_byte_t exp_pb;
        if (page_bytes_due.size() == 0) begin
            $display("%0t: unexpected result, expected none actual tdata %h tuser %b tlast %b",
                     $time, m_tdata, m_tuser, m_tlast);
            errors++;
        end else begin
            exp_pb = page_bytes_due.pop_front();
            compare_field("page_byte", exp_pb.pbyte, m_tdata[7:0]);
            compare_field("column_index", exp_pb.col, m_tdata[14:8]);
            compare_field("page_index", exp_pb.page, m_tdata[17:15]);
            compare_field("frame_end", exp_pb.fend, m_tuser);
            compare_field("run_last", exp_pb.last, m_tlast);
        end
    endtask

    // monitor: sample both channels at the rising edge
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end else begin
            in_taken  = aresetn && s_tvalid && s_tready;
            out_taken = aresetn && m_tvalid && m_tready;
            if (in_taken) dither_pixel(s_tdata);
            if (out_taken) check_page_byte();
        end
    end

    // driver: change inputs at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            v_next = s_tvalid;
            d_next = s_tdata;
            if (in_taken) begin
                v_next = 1'b0;
                sent_cnt++;
                if (sent_cnt % 256 == 0) tx_max = (2 ** $urandom_range(0, 2) - 1) * 6;
                tx_gap = $urandom_range(0, tx_max);
            end
            if (!v_next) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pixels_pending.size() > 0 &&
                             !(pixels_pending[0].drain && page_bytes_due.size() > 0)) begin
                    // a drain-marked pixel holds until every pending byte is out
                    d_next = pixels_pending[0].gray;
                    v_next = 1'b1;
                    void'(pixels_pending.pop_front());
                end
            end
            s_tvalid <= v_next;
            s_tdata  <= d_next;

            if (out_taken) begin
                recv_cnt++;
                if (recv_cnt % 128 == 0) rx_max = (2 ** $urandom_range(0, 2) - 1) * 6;
                rx_stall = $urandom_range(0, rx_max);
            end
            if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        pixel_t     px;
        logic [7:0] pair_level [W/2];
        int         gen_row;
        int         gen_col;
        int         row_mode;
        gen_row  = 0;
        gen_col  = 0;
        row_mode = 0;
        for (int n = 0; n < PIXEL_CNT; n++) begin
            if (gen_col == 0 && gen_row % 2 == 0) begin
                // one content mode per row pair; flat levels put block averages on thresholds
                row_mode = $urandom_range(0, 3);
                foreach (pair_level[k]) pair_level[k] = level_marks[$urandom_range(0, 9)];
            end
            if (n < 24) begin
                px.gray = opening_px[n];
            end else begin
                case (row_mode)
                    0: px.gray = 8'($urandom_range(0, 255));
                    1: px.gray = pair_level[gen_col / 2];
                    2: px.gray = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    default: px.gray = level_marks[$urandom_range(0, 9)];
                endcase
            end
            // both marks fall in the last row of the first page, while bytes stream out
            px.drain = (n == 930 || n == 1020);
            pixels_pending.push_back(px);
            gen_col++;
            if (gen_col >= W) begin
                gen_col = 0;
                gen_row = (gen_row + 1 >= H) ? 0 : gen_row + 1;
            end
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pixels_pending.size() > 0 || s_tvalid || page_bytes_due.size() > 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_WAIT) @(posedge aclk);

        if (errors == 0 && page_bytes_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            if (page_bytes_due.size() > 0) begin
                $display("%0t: %0d expected page bytes never arrived", $time,
                         page_bytes_due.size());
            end
            $display("Verification failed");
        end
        $finish;
    end

endmodule
